>>> sv/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while rst_n is low
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition that must never be true
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_PROP(lbl, !(cond))

`endif

>>> sv/lpc_pkg.sv
// package: sizes, queue item type and search states
package lpc_pkg;

  localparam int MAX_LEN = 1024;
  localparam int AW      = $clog2(MAX_LEN);
  localparam int CW      = $clog2(MAX_LEN + 1);
  localparam int START_W = 10;
  localparam int LEN_W   = 11;
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCW     = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]    char_byte;
    logic [AW-1:0] addr;
    logic          store;
    logic          last;
    logic          ovf;
    logic [CW-1:0] count;
  } lpc_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CMP,
    S_NEXT,
    S_OUT
  } lpc_state_t;

endpackage

>>> sv/lpc_if.sv
// valid/ready channel interfaces for the byte input and the result output
interface lpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;

  modport source (output valid, char_byte, is_last, input ready);
  modport sink   (input valid, char_byte, is_last, output ready);
endinterface

interface lpc_out_if import lpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [START_W-1:0] best_start;
  logic [LEN_W-1:0]   best_length;
  logic               overflow;

  modport source (output valid, best_start, best_length, overflow, input ready);
  modport sink   (input valid, best_start, best_length, overflow, output ready);
endinterface

>>> sv/longest_palindrome_center_expand.sv
// load: one byte per cycle while the 4-entry queue has room; it drains to the 1024-byte buffer
// search: starts as the final byte leaves the queue; each center loops S_CHECK and S_CMP,
// one dual-port read and one compare per matching step, then ends in S_NEXT; an odd center
// matches its own byte
// the result waits in the output register; input stalls once the queue fills during a search
// reset clears control state only; the buffer is not cleared and needs no clearing pass
module longest_palindrome_center_expand import lpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lpc_in_if.sink     in_ch,
  lpc_out_if.source  out_ch
);

  logic          push, pop, full, empty;
  lpc_item_t     push_item, head;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [7:0]    ram_wdata, ram_rdata_a, ram_rdata_b;

  lpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  lpc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  lpc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_text_buf (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  lpc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b),
    .out_ch      (out_ch)
  );

endmodule

>>> sv/lpc_ram.sv
// generic ram: one write port, two registered read ports
module lpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> sv/lpc_front.sv
// front end: takes bytes, assigns buffer slots and tracks truncation
module lpc_front import lpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lpc_in_if.sink    in_ch,
  input  logic      full,
  output logic      push,
  output lpc_item_t push_item
);

  logic [CW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic          store;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;
  assign store       = fill_r < CW'(MAX_LEN);

  always_comb begin
    push_item.char_byte = in_ch.char_byte;
    push_item.addr      = fill_r[AW-1:0];
    push_item.store     = store;
    push_item.last      = in_ch.is_last;
    push_item.ovf       = ovf_r || !store;
    push_item.count     = store ? fill_r + CW'(1) : fill_r;
  end

  always_comb begin
    fill_nxt = fill_r;
    ovf_nxt  = ovf_r;
    if (push) begin
      if (in_ch.is_last) begin
        fill_nxt = '0;
        ovf_nxt  = 1'b0;
      end else begin
        fill_nxt = push_item.count;
        ovf_nxt  = push_item.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

>>> sv/lpc_fifo.sv
// short queue of classified bytes between front and back
`include "assert_macros.svh"

module lpc_fifo import lpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lpc_item_t push_item,
  input  logic      pop,
  output lpc_item_t head,
  output logic      full,
  output logic      empty
);

  lpc_item_t       mem_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]  cnt_r, cnt_nxt;

  assign full  = cnt_r == QCW'(QDEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  `ASSERT_NEVER(a_fifo_no_overrun, push && full)
  `ASSERT_NEVER(a_fifo_no_underrun, pop && empty)

endmodule

>>> sv/lpc_back.sv
// back end: writes bytes to the buffer and runs the center expansion search
`include "assert_macros.svh"

module lpc_back import lpc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  lpc_item_t     head,
  input  logic          empty,
  output logic          pop,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic [AW-1:0] ram_raddr_a,
  output logic [AW-1:0] ram_raddr_b,
  input  logic [7:0]    ram_rdata_a,
  input  logic [7:0]    ram_rdata_b,
  lpc_out_if.source     out_ch
);

  lpc_state_t    state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          odd_r, odd_nxt;
  // lo carries one extra bit so that stepping below zero shows as the top bit
  logic [AW:0]   lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [AW-1:0] left_r, left_nxt;
  logic [CW-1:0] best_len_r, best_len_nxt;
  logic [AW-1:0] best_start_r, best_start_nxt;

  logic in_range, match, last_center;
  logic [CW-1:0] k_plus1;

  assign in_range    = !lo_r[AW] && (hi_r < n_r);
  assign match       = ram_rdata_a == ram_rdata_b;
  assign k_plus1     = CW'(k_r) + CW'(1);
  assign last_center = k_plus1 == n_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (!empty && head.last) state_nxt = S_CHECK;
      S_CHECK: state_nxt = in_range ? S_CMP : S_NEXT;
      S_CMP:   state_nxt = match ? S_CHECK : S_NEXT;
      S_NEXT:  state_nxt = (!odd_r && last_center) ? S_OUT : S_CHECK;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pop            = 1'b0;
    n_nxt          = n_r;
    ovf_nxt        = ovf_r;
    k_nxt          = k_r;
    odd_nxt        = odd_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    len_nxt        = len_r;
    left_nxt       = left_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    unique case (state_r)
      S_IDLE: begin
        pop = !empty;
        if (!empty && head.last) begin
          n_nxt          = head.count;
          ovf_nxt        = head.ovf;
          k_nxt          = '0;
          odd_nxt        = 1'b1;
          lo_nxt         = '0;
          hi_nxt         = '0;
          len_nxt        = '0;
          left_nxt       = '0;
          best_len_nxt   = '0;
          best_start_nxt = '0;
        end
      end
      S_CHECK: ;
      S_CMP: begin
        if (match) begin
          left_nxt = lo_r[AW-1:0];
          len_nxt  = len_r + ((hi_r == CW'(lo_r)) ? CW'(1) : CW'(2));
          lo_nxt   = lo_r - (AW + 1)'(1);
          hi_nxt   = hi_r + CW'(1);
        end
      end
      S_NEXT: begin
        if (len_r > best_len_r) begin
          best_len_nxt   = len_r;
          best_start_nxt = left_r;
        end
        len_nxt = '0;
        if (odd_r) begin
          // even center between k and k+1
          odd_nxt  = 1'b0;
          lo_nxt   = {1'b0, k_r};
          hi_nxt   = k_plus1;
          left_nxt = k_r;
        end else if (!last_center) begin
          k_nxt    = k_r + AW'(1);
          odd_nxt  = 1'b1;
          lo_nxt   = {1'b0, k_r + AW'(1)};
          hi_nxt   = k_plus1;
          left_nxt = k_r + AW'(1);
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  assign ram_we      = pop && head.store;
  assign ram_waddr   = head.addr;
  assign ram_wdata   = head.char_byte;
  assign ram_raddr_a = lo_r[AW-1:0];
  assign ram_raddr_b = hi_r[AW-1:0];

  assign out_ch.valid       = state_r == S_OUT;
  assign out_ch.best_start  = START_W'(best_start_r);
  assign out_ch.best_length = LEN_W'(best_len_r);
  assign out_ch.overflow    = ovf_r;

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    ovf_r        <= ovf_nxt;
    k_r          <= k_nxt;
    odd_r        <= odd_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    len_r        <= len_nxt;
    left_r       <= left_nxt;
    best_len_r   <= best_len_nxt;
    best_start_r <= best_start_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_PROP(a_cmp_in_range, (state_r == S_CMP) |-> (hi_r < n_r))
  `ASSERT_PROP(a_out_len_ok, (state_r == S_OUT) |-> (best_len_r != '0 && best_len_r <= n_r))

endmodule

>>> verif/lpc_checker.sv
// checker: watches both channels, predicts the longest palindrome and compares each result
module lpc_checker import lpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lpc_in_if    in_mon,
  lpc_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               ovf;
  } span_t;

  logic [7:0] text_mem [MAX_LEN];
  int         fill;
  logic       dropped;
  span_t      span_q[$];
  int         n_fail;
  int         n_res;

  // center expansion over the first n stored bytes, strictly longer wins
  function automatic span_t find_longest(int n, logic ovf);
    span_t r;
    int    best_start, best_len, k, pass, lo, hi, left, len;
    best_start = 0;
    best_len   = 0;
    for (k = 0; k < n; k++) begin
      for (pass = 0; pass < 2; pass++) begin
        lo   = k;
        hi   = k + pass;
        left = k;
        len  = 0;
        while (lo >= 0 && hi < n && text_mem[lo] == text_mem[hi]) begin
          left = lo;
          len  = len + ((hi == lo) ? 1 : 2);
          lo--;
          hi++;
        end
        if (len > best_len) begin
          best_len   = len;
          best_start = left;
        end
      end
    end
    r.start  = best_start[START_W-1:0];
    r.length = best_len[LEN_W-1:0];
    r.ovf    = ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    span_t want;
    span_t got;
    if (!rst_n) begin
      fill    = 0;
      dropped = 1'b0;
      n_fail  = 0;
      n_res   = 0;
      span_q.delete();
    end else begin
      // results first: a result can never belong to a string that ends on the same edge
      if (out_mon.valid && out_mon.ready) begin
        got.start  = out_mon.best_start;
        got.length = out_mon.best_length;
        got.ovf    = out_mon.overflow;
        n_res++;
        if (span_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: unexpected result start=%0d length=%0d overflow=%0b",
                     $realtime, got.start, got.length, got.ovf);
        end else begin
          want = span_q.pop_front();
          if (got.start !== want.start || got.length !== want.length ||
              got.ovf !== want.ovf) begin
            n_fail++;
            if (n_fail <= 10)
              $display("%0t: result %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       $realtime, n_res, want.start, want.length, want.ovf,
                       got.start, got.length, got.ovf);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (fill < MAX_LEN) begin
          text_mem[fill] = in_mon.char_byte;
          fill++;
        end else begin
          dropped = 1'b1;
        end
        if (in_mon.is_last) begin
          span_q.push_back(find_longest(fill, dropped));
          fill    = 0;
          dropped = 1'b0;
        end
      end
    end
    fail_count   <= n_fail;
    pending      <= span_q.size();
    result_count <= n_res;
  end

endmodule

>>> verif/longest_palindrome_center_expand_tb.sv
// testbench top: clock, reset, string stimulus, output back-pressure and verdict
module longest_palindrome_center_expand_tb import lpc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 500000;
  localparam int LONG_HOLD    = 400;

  logic clk;
  logic rst_n;

  lpc_in_if  in_if ();
  lpc_out_if out_if ();

  int fail_count;
  int pending;
  int result_count;

  logic       no_idle;
  logic       hold_req;
  logic [7:0] str_q[$];
  int         sent_bytes;
  int         sent_strings;
  int         truncated;
  int         cycles;

  longest_palindrome_center_expand u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  lpc_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side: short random stalls, one long hold on request
  initial begin
    bit held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_if.valid     <= 1'b1;
    in_if.char_byte <= b;
    in_if.is_last   <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent_bytes++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_string();
    int i;
    for (i = 0; i < str_q.size(); i++)
      send_byte(str_q[i], i == str_q.size() - 1);
    if (str_q.size() > MAX_LEN)
      truncated++;
    sent_strings++;
    str_q.delete();
  endtask

  task automatic make_short_string();
    int         kind, n, i, half, base;
    logic [7:0] a, b;
    kind = $urandom_range(0, 3);
    a    = 8'($urandom_range(0, 255));
    b    = 8'($urandom_range(0, 255));
    case (kind)
      0: begin
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) str_q.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        // two-symbol alphabet gives plenty of overlapping palindromes and ties
        n = $urandom_range(1, 16);
        for (i = 0; i < n; i++) str_q.push_back($urandom_range(0, 1) ? a : b);
      end
      2: begin
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) str_q.push_back(8'($urandom_range(0, 255)));
        base = str_q.size();
        half = $urandom_range(1, 5);
        for (i = 0; i < half; i++) str_q.push_back($urandom_range(0, 1) ? a : b);
        if ($urandom_range(0, 1)) str_q.push_back(8'($urandom_range(0, 255)));
        for (i = half - 1; i >= 0; i--) str_q.push_back(str_q[base + i]);
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) str_q.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        n = $urandom_range(1, 2);
        for (i = 0; i < n; i++) str_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  initial begin
    int i;
    no_idle         = 1'b0;
    hold_req        = 1'b0;
    sent_bytes      = 0;
    sent_strings    = 0;
    truncated       = 0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.char_byte <= 8'h00;
    in_if.is_last   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single bytes at both extremes
    str_q = '{8'h00};
    send_string();
    str_q = '{8'hff};
    send_string();
    // even center
    str_q = '{8'h12, 8'h34, 8'h34, 8'h12};
    send_string();
    // odd center
    str_q = '{8'h80, 8'h01, 8'h80};
    send_string();
    // no pair matches, earliest single byte wins
    str_q = '{8'h01, 8'h02};
    send_string();
    // two equal-length pairs, the earlier one is kept
    str_q = '{8'h05, 8'h07, 8'h07, 8'h09, 8'h09};
    send_string();
    // one repeated byte
    str_q = '{8'hc3, 8'hc3, 8'hc3, 8'hc3};
    send_string();

    // random part, opened by a long hold on the result side
    hold_req = 1'b1;
    while (sent_bytes < 690) begin
      make_short_string();
      send_string();
    end

    // buffer overrun: the last two bytes are not stored; the final flag still ends the string
    for (i = 0; i < MAX_LEN + 2; i++)
      str_q.push_back($urandom_range(0, 1) ? 8'h41 : 8'h42);
    send_string();

    // closing stretch at full rate on both sides
    no_idle = 1'b1;
    while (sent_bytes < 1850) begin
      make_short_string();
      send_string();
    end
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("sent %0d strings (%0d bytes, %0d truncated), %0d results checked, %0d cycles",
             sent_strings, sent_bytes, truncated, result_count, cycles);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
